// ----- sv/stdet_pkg.sv -----
// Package for the sensitive text detector: history cell type, tag constants,
// register codes and character class helpers. Depends on nothing.
package stdet_pkg;

  // History depth in bytes and run counter width
  localparam int unsigned HistLen = 10;
  localparam int unsigned RunW    = 5;
  localparam logic [RunW-1:0] RunMax = {RunW{1'b1}};

  // APB address width and data width
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // Prefixes, oldest character in the most significant byte
  localparam logic [23:0] TagSk     = "sk-";
  localparam logic [31:0] TagGhp    = "ghp_";
  localparam logic [31:0] TagAkia   = "AKIA";
  localparam logic [55:0] TagBearer = "Bearer ";
  localparam logic [7:0]  ChDash    = "-";
  localparam logic [7:0]  ChSpace   = " ";

  // Register codes, taken from address bit 2
  typedef enum logic {
    REG_CHECK_PII     = 1'b0,
    REG_CHECK_SECRETS = 1'b1
  } reg_idx_e;

  // Contents of one history cell
  typedef struct packed {
    logic [7:0] text_byte;
    logic       digit;
  } cell_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ----- sv/stdet_if.sv -----
// Handshake channels of the sensitive text detector: text bytes in, results out.
// Depends on nothing.
interface stdet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface stdet_out_if;
  logic valid;
  logic ready;
  logic sensitive_found;

  modport source (output valid, sensitive_found, input ready);
  modport sink   (input valid, sensitive_found, output ready);
endinterface

// ----- sv/stdet_cell.sv -----
// One history cell: holds a byte and its digit class, loads from its neighbor.
// Depends on stdet_pkg.
module stdet_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  logic              clear_i,
  input  logic [7:0]        byte_i,
  output stdet_pkg::cell_t  cell_o
);
  import stdet_pkg::*;

  cell_t cell_q;

  // Load the neighbor byte on each request, drop it at text end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (clear_i) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q.text_byte <= byte_i;
      cell_q.digit     <= is_digit(byte_i);
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- sv/stdet_run.sv -----
// Saturating counter of digits in a run of digits, spaces and dashes.
// Depends on stdet_pkg.
module stdet_run #(
  parameter int unsigned CARD_DIGITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic                       clear_i,
  input  logic                       digit_i,
  input  logic                       sep_i,
  output logic                       hit_o,
  output logic [stdet_pkg::RunW-1:0] count_o
);
  import stdet_pkg::*;

  logic [RunW-1:0] count_q, count_d;

  // Count digits, hold on separators, drop on anything else
  always_comb begin
    if (digit_i) begin
      count_d = (count_q == RunMax) ? count_q : count_q + RunW'(1);
    end else if (sep_i) begin
      count_d = count_q;
    end else begin
      count_d = '0;
    end
  end

  assign hit_o = (count_d >= RunW'(CARD_DIGITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i) begin
      count_q <= clear_i ? '0 : count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ----- sv/sensitive_text_detector_core.sv -----
// Channel   Dir  Payload                       Accepted when
// text_i    in   text_byte[7:0], end_of_text   text_i.valid && text_i.ready
// result_o  out  sensitive_found               result_o.valid && result_o.ready
// apb       in   check_pii @0, check_secrets @4 psel && penable && pwrite
//
// One byte per cycle; every pattern is matched in the cycle the byte is taken,
// against a ten-cell history chain that shifts one cell per request.
// A result is registered at the edge that takes the end-of-text byte and is offered
// from the next cycle on.
// Input stalls only while a result is held and the sink is not ready.
// Reset clears the history, run counter, sticky flag and result valid; registers go to 1.
// Top level; depends on stdet_pkg, stdet_if, stdet_cell and stdet_run.
module sensitive_text_detector_core #(
  parameter int unsigned CARD_DIGITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  stdet_in_if.sink                     text_i,
  stdet_out_if.source                  result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stdet_pkg::AddrW-1:0]  paddr,
  input  logic [stdet_pkg::DataW-1:0]  pwdata,
  output logic [stdet_pkg::DataW-1:0]  prdata,
  output logic                         pready
);
  import stdet_pkg::*;

  logic check_pii_q, check_secrets_q;
  logic found_q, found_d;
  logic res_valid_q, res_data_q;
  logic accept, clear, reg_wr;
  logic [HistLen:0][7:0] win_w;
  logic [HistLen:0]      dig_w;
  cell_t [HistLen-1:0]   cells;
  logic run_hit, num_hit, sec_hit;
  logic [RunW-1:0] run_count;
  reg_idx_e reg_idx;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_pii_q     <= 1'b1;
      check_secrets_q <= 1'b1;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_CHECK_PII:     check_pii_q     <= pwdata[0];
        REG_CHECK_SECRETS: check_secrets_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHECK_PII:     prdata = {{(DataW-1){1'b0}}, check_pii_q};
      REG_CHECK_SECRETS: prdata = {{(DataW-1){1'b0}}, check_secrets_q};
      default:           prdata = '0;
    endcase
  end

  // Handshake: take a byte whenever the result slot is free or draining
  assign text_i.ready = !res_valid_q || result_o.ready;
  assign accept       = text_i.valid && text_i.ready;
  assign clear        = accept && text_i.end_of_text;

  // History chain, newest byte in cell 0
  for (genvar k = 0; k < HistLen; k++) begin : g_cell
    stdet_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .clear_i (clear),
      .byte_i  (win_w[k]),
      .cell_o  (cells[k])
    );
  end

  // Window: current byte at 0, older bytes above
  always_comb begin
    win_w[0] = text_i.text_byte;
    dig_w[0] = is_digit(text_i.text_byte);
    for (int k = 0; k < HistLen; k++) begin
      win_w[k+1] = cells[k].text_byte;
      dig_w[k+1] = cells[k].digit;
    end
  end

  stdet_run #(
    .CARD_DIGITS (CARD_DIGITS)
  ) u_run (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .clear_i   (clear),
    .digit_i   (dig_w[0]),
    .sep_i     ((win_w[0] == ChSpace) || (win_w[0] == ChDash)),
    .hit_o     (run_hit),
    .count_o   (run_count)
  );

  // DDD-DD-DDDD ending at the current byte
  assign num_hit = (&dig_w[10:8]) && (win_w[7] == ChDash) && (&dig_w[6:5])
                && (win_w[4] == ChDash) && (&dig_w[3:0]);

  assign sec_hit = (win_w[2:0] == TagSk) || (win_w[3:0] == TagGhp)
                || (win_w[3:0] == TagAkia) || (win_w[6:0] == TagBearer);

  assign found_d = found_q || (check_pii_q && (num_hit || run_hit))
                || (check_secrets_q && sec_hit);

  // Sticky flag, dropped at text end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (accept) begin
      found_q <= text_i.end_of_text ? 1'b0 : found_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (clear) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear) begin
      res_data_q <= found_d;
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.sensitive_found = res_data_q;

`ifndef SYNTHESIS
  // State is empty right after a text ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |=> (!found_q && run_count == '0 && cells[0] == '0))
    else $error("state not cleared after end of text");

  // A result only appears after an end-of-text request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(clear))
    else $error("result without end of text");

  // Never take a byte while a held result is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !result_o.ready) |-> !accept)
    else $error("byte accepted over a stalled result");
`endif

endmodule
